/* rtl/rss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

    // default sizing
    localparam int DEPTH_DEFAULT      = 256;
    localparam int VALUE_BITS_DEFAULT = 16;

    // fixed field widths
    localparam int TIMESTAMP_BITS = 32;
    localparam int TOTAL_BITS     = 48;
    localparam int MEAN_FRAC_BITS = 4;
    localparam int CMD_BITS       = 2;

    // command codes carried in s_tuser
    localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic clear;
        logic set_drop;
        logic add_stats;
        logic ins_start;
        logic ins_shift;
        logic ins_place;
        logic div_start;
        logic rd_mid;
        logic rd_mid_lo;
        logic cap_med_hi;
        logic cap_med_lo;
        logic load_out;
    } rss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic even;
        logic rd_gt;
        logic at_bottom;
        logic div_done;
        logic out_free;
    } rss_status_t;

endpackage

`default_nettype wire

/* rtl/rss_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/rss_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// unsigned restoring divider, one quotient bit per cycle
module rss_div #(
    parameter int NUM_BITS = 29,
    parameter int DEN_BITS = 9
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] dividend,
    input  wire logic [DEN_BITS-1:0] divisor,
    output logic                     done,
    output logic      [NUM_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_BITS-2:0], ge};
            rem_next = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/rss_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rss_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic [rss_pkg::CMD_BITS-1:0]  s_tuser,
    output logic                               s_tready,
    input  wire rss_pkg::rss_status_t          status,
    output rss_pkg::rss_cmd_t                  cmd
);

    import rss_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD    = 4'd1;
    localparam logic [3:0] S_INS    = 4'd2;
    localparam logic [3:0] S_PLACE  = 4'd3;
    localparam logic [3:0] S_CLR    = 4'd4;
    localparam logic [3:0] S_QRY    = 4'd5;
    localparam logic [3:0] S_MED_HI = 4'd6;
    localparam logic [3:0] S_MED_LO = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    case (s_tuser)
                        CMD_ADD:   state_next = S_ADD;
                        CMD_CLEAR: state_next = S_CLR;
                        CMD_QUERY: state_next = S_QRY;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                if (status.full)
                begin
                    cmd.set_drop = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.add_stats = 1'b1;
                    cmd.ins_start = 1'b1;
                    state_next    = status.empty ? S_PLACE : S_INS;
                end
            end
            S_INS:
            begin
                // walk down while the stored entry is larger than the new sample
                if (status.rd_gt)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = status.at_bottom ? S_PLACE : S_INS;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PLACE:
            begin
                cmd.ins_place = 1'b1;
                state_next    = S_IDLE;
            end
            S_CLR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            S_QRY:
            begin
                if (status.empty)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.rd_mid    = 1'b1;
                    state_next    = S_MED_HI;
                end
            end
            S_MED_HI:
            begin
                cmd.cap_med_hi = 1'b1;
                if (status.even)
                begin
                    cmd.rd_mid_lo = 1'b1;
                    state_next    = S_MED_LO;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_MED_LO:
            begin
                cmd.cap_med_lo = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/rss_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module rss_datapath #(
    parameter int DEPTH      = rss_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = rss_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire rss_pkg::rss_cmd_t                      cmd,
    output rss_pkg::rss_status_t                        status,
    input  wire logic                                   cfg_valid,
    input  wire logic signed [VALUE_BITS-1:0]           cfg_threshold,
    input  wire logic signed [VALUE_BITS-1:0]           sample_value,
    input  wire logic [rss_pkg::TIMESTAMP_BITS-1:0]     timestamp,
    input  wire logic                                   m_tready,
    output logic                                        out_valid,
    output logic                                        out_empty,
    output logic [$clog2(DEPTH+1)-1:0]                  out_count,
    output logic signed [VALUE_BITS-1:0]                out_min,
    output logic signed [VALUE_BITS-1:0]                out_max,
    output logic signed [VALUE_BITS+rss_pkg::MEAN_FRAC_BITS-1:0] out_mean,
    output logic signed [VALUE_BITS:0]                  out_median,
    output logic [rss_pkg::TOTAL_BITS-1:0]              out_under,
    output logic [rss_pkg::TOTAL_BITS-1:0]              out_over,
    output logic                                        out_overflow
);

    import rss_pkg::*;

    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int SUM_BITS   = VALUE_BITS + COUNT_BITS;
    localparam int NUM_BITS   = SUM_BITS + MEAN_FRAC_BITS;
    localparam int MEAN_BITS  = VALUE_BITS + MEAN_FRAC_BITS;
    localparam int TSUM_BITS  = TOTAL_BITS + 1;

    logic signed [VALUE_BITS-1:0]     thr_reg, thr_next;
    logic signed [VALUE_BITS-1:0]     val_in_reg;
    logic [TIMESTAMP_BITS-1:0]        ts_in_reg;
    logic [COUNT_BITS-1:0]            count_reg, count_next;
    logic signed [SUM_BITS-1:0]       sum_reg, sum_next;
    logic signed [VALUE_BITS-1:0]     min_reg, min_next;
    logic signed [VALUE_BITS-1:0]     max_reg, max_next;
    logic signed [VALUE_BITS-1:0]     prev_val_reg, prev_val_next;
    logic [TIMESTAMP_BITS-1:0]        prev_time_reg, prev_time_next;
    logic [TOTAL_BITS-1:0]            under_reg, under_next;
    logic [TOTAL_BITS-1:0]            over_reg, over_next;
    logic                             drop_reg, drop_next;
    logic [ADDR_BITS-1:0]             ptr_reg, ptr_next;
    logic signed [VALUE_BITS-1:0]     med_a_reg, med_b_reg;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_empty_reg;
    logic [COUNT_BITS-1:0]            out_count_reg;
    logic signed [VALUE_BITS-1:0]     out_min_reg, out_max_reg;
    logic signed [MEAN_BITS-1:0]      out_mean_reg;
    logic signed [VALUE_BITS:0]       out_median_reg;
    logic [TOTAL_BITS-1:0]            out_under_reg, out_over_reg;
    logic                             out_overflow_reg;

    logic [TIMESTAMP_BITS-1:0]        delta;
    logic [TSUM_BITS-1:0]             under_sum, over_sum;
    logic                             is_empty;
    logic [COUNT_BITS-1:0]            count_m1;
    logic [COUNT_BITS-1:0]            mid;
    logic [COUNT_BITS-1:0]            mid_m1;
    logic                             ram_wr_en, ram_rd_en;
    logic [ADDR_BITS-1:0]             ram_rd_addr;
    logic signed [VALUE_BITS-1:0]     ram_wr_data, ram_rd_data;
    logic [SUM_BITS-1:0]              sum_mag;
    logic [NUM_BITS-1:0]              div_num, div_quo;
    logic                             div_done;
    logic [MEAN_BITS-1:0]             mean_mag;
    logic signed [MEAN_BITS-1:0]      mean_val;
    logic signed [VALUE_BITS:0]       median_val;

    assign is_empty = (count_reg == '0);
    assign count_m1 = count_reg - COUNT_BITS'(1);
    assign mid      = count_reg >> 1;
    assign mid_m1   = mid - COUNT_BITS'(1);

    // interval since the previous sample, wrapping
    assign delta     = ts_in_reg - prev_time_reg;
    assign under_sum = {1'b0, under_reg} + TSUM_BITS'(delta);
    assign over_sum  = {1'b0, over_reg} + TSUM_BITS'(delta);

    // sorted store
    always_comb
    begin
        ram_rd_addr = '0;
        if (cmd.ins_start)
        begin
            ram_rd_addr = count_m1[ADDR_BITS-1:0];
        end
        else if (cmd.ins_shift)
        begin
            ram_rd_addr = ptr_reg - ADDR_BITS'(2);
        end
        else if (cmd.rd_mid)
        begin
            ram_rd_addr = mid[ADDR_BITS-1:0];
        end
        else if (cmd.rd_mid_lo)
        begin
            ram_rd_addr = mid_m1[ADDR_BITS-1:0];
        end
    end

    assign ram_rd_en   = cmd.ins_start | cmd.ins_shift | cmd.rd_mid | cmd.rd_mid_lo;
    assign ram_wr_en   = cmd.ins_shift | cmd.ins_place;
    assign ram_wr_data = cmd.ins_shift ? ram_rd_data : val_in_reg;

    rss_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // mean: magnitude of sum x16 divided by count, sign put back afterwards
    assign sum_mag = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    assign div_num = {sum_mag, {MEAN_FRAC_BITS{1'b0}}};

    rss_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign mean_mag   = div_quo[MEAN_BITS-1:0];
    assign mean_val   = sum_reg[SUM_BITS-1] ? MEAN_BITS'(-mean_mag) : MEAN_BITS'(mean_mag);
    assign median_val = (VALUE_BITS+1)'(med_a_reg) + (VALUE_BITS+1)'(med_b_reg);

    always_comb
    begin
        thr_next       = cfg_valid ? cfg_threshold : thr_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        prev_val_next  = prev_val_reg;
        prev_time_next = prev_time_reg;
        under_next     = under_reg;
        over_next      = over_reg;
        drop_next      = drop_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end

        if (cmd.clear)
        begin
            count_next     = '0;
            sum_next       = '0;
            min_next       = '0;
            max_next       = '0;
            prev_val_next  = '0;
            prev_time_next = '0;
            under_next     = '0;
            over_next      = '0;
            drop_next      = 1'b0;
        end
        if (cmd.set_drop)
        begin
            drop_next = 1'b1;
        end
        if (cmd.add_stats)
        begin
            if (is_empty)
            begin
                // first sample: no interval credited
                min_next = val_in_reg;
                max_next = val_in_reg;
            end
            else
            begin
                if (prev_val_reg < thr_reg)
                begin
                    under_next = under_sum[TOTAL_BITS] ? '1 : under_sum[TOTAL_BITS-1:0];
                end
                else if (prev_val_reg > thr_reg)
                begin
                    over_next = over_sum[TOTAL_BITS] ? '1 : over_sum[TOTAL_BITS-1:0];
                end
                if (val_in_reg < min_reg)
                begin
                    min_next = val_in_reg;
                end
                if (val_in_reg > max_reg)
                begin
                    max_next = val_in_reg;
                end
            end
            sum_next       = sum_reg + SUM_BITS'(val_in_reg);
            prev_val_next  = val_in_reg;
            prev_time_next = ts_in_reg;
        end
        if (cmd.ins_start)
        begin
            ptr_next = count_reg[ADDR_BITS-1:0];
        end
        if (cmd.ins_shift)
        begin
            ptr_next = ptr_reg - ADDR_BITS'(1);
        end
        if (cmd.ins_place)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            prev_val_reg  <= '0;
            prev_time_reg <= '0;
            under_reg     <= '0;
            over_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            prev_val_reg  <= prev_val_next;
            prev_time_reg <= prev_time_next;
            under_reg     <= under_next;
            over_reg      <= over_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load_in)
        begin
            val_in_reg <= sample_value;
            ts_in_reg  <= timestamp;
        end
        if (cmd.cap_med_hi)
        begin
            med_a_reg <= ram_rd_data;
            med_b_reg <= ram_rd_data;
        end
        if (cmd.cap_med_lo)
        begin
            med_b_reg <= ram_rd_data;
        end
        if (cmd.load_out)
        begin
            out_empty_reg    <= is_empty;
            out_count_reg    <= count_reg;
            out_min_reg      <= min_reg;
            out_max_reg      <= max_reg;
            out_mean_reg     <= is_empty ? '0 : mean_val;
            out_median_reg   <= is_empty ? '0 : median_val;
            out_under_reg    <= under_reg;
            out_over_reg     <= over_reg;
            out_overflow_reg <= drop_reg;
        end
    end

    assign status.full      = (count_reg == COUNT_BITS'(DEPTH));
    assign status.empty     = is_empty;
    assign status.even      = ~count_reg[0];
    assign status.rd_gt     = (ram_rd_data > val_in_reg);
    assign status.at_bottom = (ptr_reg == ADDR_BITS'(1));
    assign status.div_done  = div_done;
    assign status.out_free  = ~out_valid_reg | m_tready;

    assign out_valid    = out_valid_reg;
    assign out_empty    = out_empty_reg;
    assign out_count    = out_count_reg;
    assign out_min      = out_min_reg;
    assign out_max      = out_max_reg;
    assign out_mean     = out_mean_reg;
    assign out_median   = out_median_reg;
    assign out_under    = out_under_reg;
    assign out_over     = out_over_reg;
    assign out_overflow = out_overflow_reg;

endmodule

`default_nettype wire

/* rtl/running_sample_statistics_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// running sample statistics: logs signed samples with a 32-bit tick timestamp into a store
// kept in ascending order, and answers a query item with count, min, max, mean (x16,
// truncated toward zero), median (x2) and the saturating ticks the held values spent
// below and above the threshold. one item is worked at a time. an add walks the store
// down past every stored entry larger than the new sample, one entry per cycle through
// the single write port of the store RAM. a query waits on the bit-serial mean divider
// and then on the output register while it still holds a result. adds to a full
// store are dropped and set the overflow flag.
// the store needs no clearing pass: only entries below the count are ever read.
// the threshold may be written at any time the block is idle; cfg_ready is always high.
module running_sample_statistics_unit #(
    parameter int DEPTH      = rss_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = rss_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // item in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // sample_value, timestamp
    input  wire logic [((VALUE_BITS+rss_pkg::TIMESTAMP_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  wire logic [rss_pkg::CMD_BITS-1:0]    s_tuser,
    // item out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // count, min_value, max_value, mean_value, median_value, time_under, time_over,
    // overflow
    output logic [((($clog2(DEPTH+1)) + 4*VALUE_BITS + 5
                   + 2*rss_pkg::TOTAL_BITS + 1 + 7)/8)*8-1:0] m_tdata,
    // empty_res
    output logic                                 m_tuser,
    // threshold register
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [VALUE_BITS-1:0]           cfg_data
);

    import rss_pkg::*;

    localparam int COUNT_BITS     = $clog2(DEPTH + 1);
    localparam int MEAN_BITS      = VALUE_BITS + MEAN_FRAC_BITS;
    localparam int OUT_BITS       = COUNT_BITS + 4*VALUE_BITS + 5 + 2*TOTAL_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7)/8)*8;

    rss_cmd_t                     cmd;
    rss_status_t                  status;
    logic signed [VALUE_BITS-1:0] in_value;
    logic [TIMESTAMP_BITS-1:0]    in_time;
    logic                         out_empty;
    logic [COUNT_BITS-1:0]        out_count;
    logic signed [VALUE_BITS-1:0] out_min, out_max;
    logic signed [MEAN_BITS-1:0]  out_mean;
    logic signed [VALUE_BITS:0]   out_median;
    logic [TOTAL_BITS-1:0]        out_under, out_over;
    logic                         out_overflow;
    logic [OUT_BITS-1:0]          out_payload;

    // unpack the input item: sample in the low bits, timestamp above it
    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_time  = s_tdata[VALUE_BITS+TIMESTAMP_BITS-1:VALUE_BITS];

    // threshold writes never stall
    assign cfg_ready = 1'b1;

    rss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rss_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_threshold (cfg_data),
        .sample_value  (in_value),
        .timestamp     (in_time),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .out_empty     (out_empty),
        .out_count     (out_count),
        .out_min       (out_min),
        .out_max       (out_max),
        .out_mean      (out_mean),
        .out_median    (out_median),
        .out_under     (out_under),
        .out_over      (out_over),
        .out_overflow  (out_overflow)
    );

    // result packing, first field in the low bits, zero filled to whole bytes
    assign out_payload = {out_overflow, out_over, out_under, out_median, out_mean,
                          out_max, out_min, out_count};
    assign m_tdata     = OUT_TDATA_BITS'(out_payload);
    assign m_tuser     = out_empty;

endmodule

`default_nettype wire

/* rtl/rss_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rss_checker #(
    parameter int DEPTH      = rss_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = rss_pkg::VALUE_BITS_DEFAULT
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [rss_pkg::CMD_BITS-1:0]   s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [((($clog2(DEPTH+1)) + 4*VALUE_BITS + 5
                       + 2*rss_pkg::TOTAL_BITS + 1 + 7)/8)*8-1:0] m_tdata,
    input wire logic                           m_tuser
);

    import rss_pkg::*;

    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // the empty flag and the count agree
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[COUNT_BITS-1:0] == '0)))
    else $error("empty flag disagrees with count");

    // the count never goes beyond the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[COUNT_BITS-1:0] <= COUNT_BITS'(DEPTH)))
    else $error("count beyond store size");

    // a query keeps the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_QUERY) |=> !s_tready)
    else $error("item taken while a query is being worked");

endmodule

bind running_sample_statistics_unit rss_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
) u_rss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* test/rss_checker.sv */
`timescale 1ns / 1ps

module rss_scoreboard #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 16,
    parameter int S_W        = 48,
    parameter int M_W        = 176
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_W-1:0]        s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_W-1:0]        m_tdata,
    input  wire logic                  m_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [VALUE_BITS-1:0] cfg_data,
    output int                         outstanding,
    output int                         fail_count
);
    import rss_pkg::*;

    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int MEAN_W    = VALUE_BITS + MEAN_FRAC_BITS;
    localparam int MIN_LSB   = CNT_W;
    localparam int MAX_LSB   = MIN_LSB + VALUE_BITS;
    localparam int MEAN_LSB  = MAX_LSB + VALUE_BITS;
    localparam int MED_LSB   = MEAN_LSB + MEAN_W;
    localparam int UNDER_LSB = MED_LSB + VALUE_BITS + 1;
    localparam int OVER_LSB  = UNDER_LSB + TOTAL_BITS;
    localparam int OVF_BIT   = OVER_LSB + TOTAL_BITS;

    typedef struct {
        bit                     empty;
        logic [CNT_W-1:0]       count;
        logic [VALUE_BITS-1:0]  min_value;
        logic [VALUE_BITS-1:0]  max_value;
        logic [MEAN_W-1:0]      mean_value;
        logic [VALUE_BITS:0]    median_value;
        logic [TOTAL_BITS-1:0]  time_under;
        logic [TOTAL_BITS-1:0]  time_over;
        bit                     overflow;
    } stats_t;

    stats_t                        stats_due[$];
    logic signed [VALUE_BITS-1:0]  sorted_vals [DEPTH];
    int                            stored;
    longint                        level_sum;
    logic signed [VALUE_BITS-1:0]  lowest;
    logic signed [VALUE_BITS-1:0]  highest;
    logic signed [VALUE_BITS-1:0]  held_val;
    logic signed [VALUE_BITS-1:0]  threshold_reg;
    logic [TIMESTAMP_BITS-1:0]     held_tick;
    logic [TOTAL_BITS-1:0]         ticks_under;
    logic [TOTAL_BITS-1:0]         ticks_over;
    bit                            dropped;
    int                            errors = 0;

    function automatic logic [TOTAL_BITS-1:0] sat_total(input logic [TOTAL_BITS-1:0] acc,
                                                        input logic [TIMESTAMP_BITS-1:0] delta);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, acc} + delta;
        return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
    endfunction

    task automatic wipe_log();
        stored      = 0;
        level_sum   = 0;
        lowest      = '0;
        highest     = '0;
        held_val    = '0;
        held_tick   = '0;
        ticks_under = '0;
        ticks_over  = '0;
        dropped     = 0;
    endtask

    task automatic log_sample(input logic signed [VALUE_BITS-1:0] v,
                              input logic [TIMESTAMP_BITS-1:0] tick);
        int pos;
        logic [TIMESTAMP_BITS-1:0] delta;
        if (stored >= DEPTH)
        begin
            dropped = 1;
            return;
        end
        if (stored > 0)
        begin
            // interval belongs to the value held before this sample
            delta = tick - held_tick;
            if (held_val < threshold_reg)
                ticks_under = sat_total(ticks_under, delta);
            else if (held_val > threshold_reg)
                ticks_over = sat_total(ticks_over, delta);
            if (v < lowest)
                lowest = v;
            if (v > highest)
                highest = v;
        end
        else
        begin
            lowest  = v;
            highest = v;
        end
        pos = 0;
        while (pos < stored && sorted_vals[pos] <= v)
            pos++;
        for (int i = stored; i > pos; i--)
            sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = v;
        stored++;
        level_sum += v;
        held_val  = v;
        held_tick = tick;
    endtask

    function automatic stats_t query_stats();
        stats_t r;
        longint mean;
        longint med;
        int     mid;
        mean = 0;
        med  = 0;
        if (stored > 0)
        begin
            mid  = stored / 2;
            mean = (level_sum * (1 << MEAN_FRAC_BITS)) / longint'(stored);
            if (stored % 2)
                med = 2 * longint'(sorted_vals[mid]);
            else
                med = longint'(sorted_vals[mid]) + longint'(sorted_vals[mid-1]);
        end
        r.empty        = (stored == 0);
        r.count        = stored[CNT_W-1:0];
        r.min_value    = (stored > 0) ? lowest : '0;
        r.max_value    = (stored > 0) ? highest : '0;
        r.mean_value   = mean[MEAN_W-1:0];
        r.median_value = med[VALUE_BITS:0];
        r.time_under   = ticks_under;
        r.time_over    = ticks_over;
        r.overflow     = dropped;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        stats_t want;
        if (stats_due.size() == 0)
        begin
            $display("%0t ns: result item with no expectation waiting, tdata %h tuser %b",
                     $time, m_tdata, m_tuser);
            errors++;
            return;
        end
        want = stats_due.pop_front();
        check_field("empty_res", want.empty, m_tuser);
        check_field("count", want.count, m_tdata[CNT_W-1:0]);
        check_field("min_value", want.min_value, m_tdata[MIN_LSB +: VALUE_BITS]);
        check_field("max_value", want.max_value, m_tdata[MAX_LSB +: VALUE_BITS]);
        check_field("mean_value", want.mean_value, m_tdata[MEAN_LSB +: MEAN_W]);
        check_field("median_value", want.median_value, m_tdata[MED_LSB +: VALUE_BITS+1]);
        check_field("time_under", want.time_under, m_tdata[UNDER_LSB +: TOTAL_BITS]);
        check_field("time_over", want.time_over, m_tdata[OVER_LSB +: TOTAL_BITS]);
        check_field("overflow", want.overflow, m_tdata[OVF_BIT]);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            wipe_log();
            threshold_reg = '0;
            stats_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold_reg = cfg_data;
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    CMD_ADD:   log_sample(s_tdata[VALUE_BITS-1:0],
                                          s_tdata[VALUE_BITS +: TIMESTAMP_BITS]);
                    CMD_CLEAR: wipe_log();
                    CMD_QUERY: stats_due = {stats_due, query_stats()};
                    default:   ;
                endcase
            end
        end
        outstanding <= stats_due.size();
        fail_count  <= errors;
    end

endmodule

/* test/tb_running_sample_statistics_unit.sv */
`timescale 1ns / 1ps

module tb_running_sample_statistics_unit;
    import rss_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int VB    = VALUE_BITS_DEFAULT;
    // packed widths of the two data buses, same rule as the block's port list
    localparam int S_W   = ((VB + TIMESTAMP_BITS + 7) / 8) * 8;
    localparam int M_W   = (($clog2(DEPTH + 1) + 4*VB + 5 + 2*TOTAL_BITS + 1 + 7) / 8) * 8;

    // command 3 is not decoded by the block, used here as noise
    localparam logic [CMD_BITS-1:0] CMD_RESERVED = 2'd3;

    // the last add that fits may walk every stored entry, so the block may stay busy
    // after the last result; wait this out before any register write
    localparam int SETTLE_CYCLES = DEPTH + 8;
    // longest quiet stretch of a correct run is an add that walks the whole store plus
    // the settle pause and the idling draws
    localparam int QUIET_LIMIT   = 5000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata = '0;       // sample_value, timestamp
    logic [CMD_BITS-1:0]   s_tuser = CMD_ADD;  // command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // count, min_value, max_value, mean_value, median_value, time_under, time_over, overflow
    logic [M_W-1:0]        m_tdata;
    logic                  m_tuser;            // empty_res
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [VB-1:0]         cfg_data = '0;

    int                    outstanding;
    int                    fail_count;
    int                    quiet_cycles = 0;
    int                    rx_hold = 0;
    int                    rx_draw;
    bit                    calm = 1'b0;        // both sides run without idling while set
    int                    thr_now = 0;        // threshold last written, steers sample values
    logic [31:0]           tick_now = '0;

    running_sample_statistics_unit #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rss_scoreboard #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VB),
        .S_W        (S_W),
        .M_W        (M_W)
    ) stats_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: after each accepted result item draw a stall at random, or none while calm
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end
        else if (m_tready)
        begin
            if (m_tvalid)
            begin
                rx_draw = calm ? 0 : $urandom_range(0, 15);
                if (rx_draw != 0)
                begin
                    m_tready <= 1'b0;
                    rx_hold  <= rx_draw - 1;
                end
            end
        end
        else if (rx_hold == 0)
            m_tready <= 1'b1;
        else
            rx_hold <= rx_hold - 1;
    end

    // watchdog: any handshake restarts the count of quiet cycles
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("running_sample_statistics_unit verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one item on the input channel, after a random gap unless calm
    // called and returns on a rising edge
    task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [VB-1:0] value,
                             input logic [31:0] tick);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_W'({tick, value});
        do @(posedge clk); while (!s_tready);
    endtask

    // hold off the sender until every expected result item has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // threshold write only with the block idle: drain, then let a pending add finish
    task automatic set_threshold(input int value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[VB-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_now = value;
    endtask

    // sample values: extremes, values around the threshold, small values that
    // repeat often, and the full range
    function automatic logic [VB-1:0] pick_value();
        int kind;
        int v;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       v = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2:    v = thr_now + int'($urandom_range(0, 4)) - 2;
            3, 4:    v = int'($urandom_range(0, 16)) - 8;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[VB-1:0];
    endfunction

    // timestamps mostly climb slowly; sometimes jump, wrap, step back or scatter
    function automatic logic [31:0] next_tick();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind == 0)
            tick_now = $urandom;
        else if (kind == 1)
            tick_now = tick_now - $urandom_range(1, 5000);
        else if (kind == 2)
            tick_now = tick_now + $urandom;
        else
            tick_now = tick_now + $urandom_range(0, 1000);
        return tick_now;
    endfunction

    // mostly adds with queries mixed in; clears at the given rate; a little
    // noise with the undecoded command that is not counted
    task automatic run_random(input int n_items, input int clear_pct, input int query_pct);
        int done;
        int r;
        done = 0;
        while (done < n_items)
        begin
            if ($urandom_range(0, 29) == 0)
                calm <= !calm;
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(CMD_RESERVED, VB'($urandom), $urandom);
            else
            begin
                if (r < 4 + clear_pct)
                    send_item(CMD_CLEAR, VB'($urandom), $urandom);
                else if (r < 4 + clear_pct + query_pct)
                    send_item(CMD_QUERY, VB'($urandom), $urandom);
                else
                    send_item(CMD_ADD, pick_value(), next_tick());
                done++;
            end
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, threshold at zero
        set_threshold(0);
        send_item(CMD_QUERY, '0, '0);                   // empty store after reset
        send_item(CMD_ADD, 16'h7FFF, 32'hFFFF_FFF0);    // first sample, no interval credited
        send_item(CMD_ADD, 16'h8000, 32'h0000_0010);    // tick wraps, held max goes over
        send_item(CMD_QUERY, '1, '1);                   // even count of two
        send_item(CMD_ADD, 16'h0000, 32'h0000_0100);    // held min goes under
        send_item(CMD_ADD, 16'h0005, 32'h0000_0080);    // held value at threshold, tick backwards
        send_item(CMD_ADD, 16'h0005, 32'hFFFF_FFFF);    // duplicate value, large interval
        send_item(CMD_QUERY, '0, '0);                   // odd count
        send_item(CMD_RESERVED, '1, '1);                // ignored command
        send_item(CMD_QUERY, '0, '0);
        send_item(CMD_ADD, 16'hFFFF, 32'h0000_0000);
        send_item(CMD_ADD, 16'hFFFD, 32'h0000_0007);    // positive mean that does not divide evenly, truncated
        send_item(CMD_QUERY, '0, '0);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_QUERY, '0, '0);                   // everything zero after clear
        send_item(CMD_ADD, 16'h8000, 32'h1234_5678);    // first sample after clear
        send_item(CMD_ADD, 16'h8000, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 16'h7FFF, 32'h0000_0000);
        send_item(CMD_QUERY, '0, '0);
        send_item(CMD_CLEAR, '1, '1);

        // lowest threshold: nothing can be under it
        set_threshold(-32768);
        run_random(150, 3, 18);

        // highest threshold, no clears: the store fills and further adds drop
        set_threshold(32767);
        send_item(CMD_CLEAR, '0, '0);
        run_random(380, 0, 12);

        set_threshold($urandom_range(0, 65535) - 32768);
        run_random(200, 4, 20);

        // threshold near zero, where the small sample values sit
        set_threshold($urandom_range(0, 100) - 50);
        run_random(200, 3, 20);

        set_threshold($urandom_range(0, 65535) - 32768);
        run_random(120, 5, 22);

        // wind down: all results back, then give a last add time to finish
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("running_sample_statistics_unit verification clean");
        else
            $display("running_sample_statistics_unit verification failed");
        $finish;
    end

endmodule
